>>> hw/rtl/cfa_pkg.sv
`timescale 1ns / 1ps

package cfa_pkg;

  localparam int MAX_FRAMES_DEF = 1024;
  localparam int FRAME_W        = 20;
  localparam int COUNT_W        = 11;

  // Frame states as held in the table.
  localparam logic [1:0] ST_FREE  = 2'b00;
  localparam logic [1:0] ST_HEAD  = 2'b01;
  localparam logic [1:0] ST_ALLOC = 2'b11;

  // Request kinds.
  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_ALLOC   = 2'd1;
  localparam logic [1:0] KIND_MARK    = 2'd2;
  localparam logic [1:0] KIND_RELEASE = 2'd3;

  // Status codes.
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_NOSPACE = 2'd1;
  localparam logic [1:0] STS_RANGE   = 2'd2;
  localparam logic [1:0] STS_NOTHEAD = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BASE    = 2'd0;
  localparam logic [1:0] CFG_POOL    = 2'd1;
  localparam logic [1:0] CFG_RESERVE = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [FRAME_W-1:0] frame_no;
    logic [COUNT_W-1:0] count;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FRAME_W-1:0] result_frame;
    logic [COUNT_W-1:0] free_frames;
  } rsp_t;

  typedef struct packed {
    logic       load;
    logic       sweep;
    logic       sweep_req;
    logic       scan;
    logic       rmw_rd;
    logic       rmw_wr;
    logic       set_status;
    logic [1:0] status_code;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       cnt_zero;
    logic       mark_bad;
    logic       rel_bad;
    logic       sweep_last;
    logic       found;
    logic       scan_end;
    logic       rmw_more;
    logic       not_head;
  } sts_t;

endpackage

>>> hw/rtl/contiguous_frame_allocator.sv
`timescale 1ns / 1ps

// First-fit allocator of contiguous frame runs over a table of 2-bit frame
// states, held four frames to a word in one memory of MAX_FRAMES/4 words.
// One request is handled at a time and gives one response. After reset the
// table is cleared word by word before the first request is taken;
// configuration writes are taken throughout. A clear sweeps every word of
// the table. An allocate searches one word per cycle until it finds a run or
// gives up, and then reads and writes back each table word of the run to mark
// it. A mark request reads and writes back each word touched, and a release
// each word until the end of the sequence. A request refused on its count or
// range goes straight to its response.

module contiguous_frame_allocator import cfa_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [FRAME_W-1:0] cfg_data,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_t               rsp
);

  cmd_t cmd;
  sts_t sts;

  cfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cfa_dp #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule

>>> hw/rtl/cfa_dp.sv
`timescale 1ns / 1ps

module cfa_dp import cfa_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [FRAME_W-1:0] cfg_data,
  input  req_t               req,
  input  cmd_t               cmd,
  output sts_t               sts,
  output rsp_t               rsp
);

  localparam int DEPTH = MAX_FRAMES / 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_FRAMES + 1);
  localparam int XW    = IW + 1;

  // Configuration.
  logic [FRAME_W-1:0] base;
  logic [COUNT_W-1:0] pool;
  logic               reserve;

  // Request and working registers.
  logic [1:0]         kind_r;
  logic [FRAME_W-1:0] fno_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [1:0]         status_r;
  logic [FRAME_W-1:0] result_r;
  logic [COUNT_W-1:0] fc;
  logic [AW:0]        sw;
  logic [AW:0]        wp;
  logic [COUNT_W-1:0] run;
  logic [IW-1:0]      start;
  logic [IW-1:0]      stop_idx;
  logic               act;
  logic               first;
  logic               rd_pend;
  logic [XW-1:0]      pend_base;

  // State table, four frames to a word.
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata;
  logic [7:0]    wdata;
  logic          we;
  logic          re;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  logic [IW-1:0]      n;
  logic [XW-1:0]      n_x;
  logic [XW-1:0]      start_x;
  logic [XW-1:0]      stop_x;
  logic [FRAME_W-1:0] req_off;
  logic [21:0]        hi_req;
  logic [21:0]        hi_pool;
  logic               issue;
  logic               rel;
  logic               res_head;

  logic [COUNT_W-1:0] run_c;
  logic [IW-1:0]      start_c;
  logic               found_c;
  logic [XW-1:0]      hit_c;

  logic [COUNT_W-1:0] fc_c;
  logic               act_c;
  logic [7:0]         word_c;
  logic               not_head_c;
  logic               more_c;

  always_comb begin
    if (32'(pool) > MAX_FRAMES) begin
      n = IW'(MAX_FRAMES);
    end else begin
      n = IW'(pool);
    end
  end

  assign n_x      = XW'(n);
  assign start_x  = XW'(start);
  assign stop_x   = XW'(stop_idx);
  assign req_off  = req.frame_no - base;
  assign hi_req   = {2'b00, fno_r} + {11'd0, cnt_r};
  assign hi_pool  = {2'b00, base} + 22'(n);
  assign issue    = cmd.scan && (XW'({sw, 2'b00}) < n_x);
  assign rel      = (kind_r == KIND_RELEASE);
  assign res_head = reserve && (n != '0);

  // First-fit search over the word that arrived from the previous read.
  always_comb begin
    logic [XW-1:0] fidx;
    logic [1:0]    st;
    run_c   = run;
    start_c = start;
    found_c = 1'b0;
    hit_c   = {XW{1'b0}};
    for (int j = 0; j < 4; j++) begin
      fidx = pend_base + XW'(j);
      st   = rdata[2*j +: 2];
      if (cmd.scan && rd_pend && !found_c && (fidx < n_x)) begin
        if (st == ST_FREE) begin
          if (run_c == '0) begin
            start_c = IW'(fidx);
          end
          run_c = run_c + COUNT_W'(1);
          if (run_c == cnt_r) begin
            found_c = 1'b1;
            hit_c   = fidx;
          end
        end else begin
          run_c = '0;
        end
      end
    end
  end

  // Read-modify-write of one word for marking or releasing a run.
  always_comb begin
    logic [XW-1:0] wb;
    logic [XW-1:0] fidx;
    logic [1:0]    old;
    logic [1:0]    head_st;
    wb         = XW'({wp, 2'b00});
    fc_c       = fc;
    act_c      = act;
    word_c     = rdata;
    head_st    = rdata[2*start[1:0] +: 2];
    not_head_c = rel && first && (head_st != ST_HEAD);
    for (int j = 0; j < 4; j++) begin
      fidx = wb + XW'(j);
      old  = rdata[2*j +: 2];
      if (!rel) begin
        if ((fidx >= start_x) && (fidx < stop_x)) begin
          if ((old == ST_FREE) && (fc_c != '0)) begin
            fc_c = fc_c - COUNT_W'(1);
          end
          word_c[2*j +: 2] = (fidx == start_x) ? ST_HEAD : ST_ALLOC;
        end
      end else if (fidx >= start_x) begin
        // The head itself always goes; followers only while the run lasts.
        if ((fidx == start_x) || (act_c && (fidx < n_x) && (old == ST_ALLOC))) begin
          if ((old != ST_FREE) && (fc_c != COUNT_MAX)) begin
            fc_c = fc_c + COUNT_W'(1);
          end
          word_c[2*j +: 2] = ST_FREE;
        end else begin
          act_c = 1'b0;
        end
      end
    end
    if (rel) begin
      more_c = act_c && ((wb + XW'(4)) < n_x);
    end else begin
      more_c = (wb + XW'(4)) < stop_x;
    end
  end

  // Memory ports.
  always_comb begin
    we    = cmd.sweep || (cmd.rmw_wr && !not_head_c);
    re    = issue || cmd.rmw_rd;
    waddr = cmd.sweep ? sw[AW-1:0] : wp[AW-1:0];
    raddr = cmd.scan ? sw[AW-1:0] : wp[AW-1:0];
    if (cmd.sweep) begin
      if (cmd.sweep_req && (sw == '0) && res_head) begin
        wdata = {6'd0, ST_HEAD};
      end else begin
        wdata = 8'd0;
      end
    end else begin
      wdata = word_c;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base     <= '0;
      pool     <= COUNT_W'(1024);
      reserve  <= 1'b0;
      fc       <= '0;
      sw       <= '0;
      rd_pend  <= 1'b0;
      status_r <= STS_OK;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE:    base    <= cfg_data;
          CFG_POOL:    pool    <= cfg_data[COUNT_W-1:0];
          CFG_RESERVE: reserve <= cfg_data[0];
          default:     ;
        endcase
      end
      rd_pend <= issue;
      if (cmd.load) begin
        sw       <= '0;
        status_r <= STS_OK;
      end else if (cmd.sweep || issue) begin
        sw <= sw + (AW+1)'(1);
      end
      if (cmd.set_status) begin
        status_r <= cmd.status_code;
      end
      if (cmd.sweep && cmd.sweep_req && sts.sweep_last) begin
        fc <= res_head ? (COUNT_W'(n) - COUNT_W'(1)) : COUNT_W'(n);
      end else if (cmd.rmw_wr && !not_head_c) begin
        fc <= fc_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= req.kind;
      fno_r    <= req.frame_no;
      cnt_r    <= req.count;
      result_r <= '0;
      run      <= '0;
      start    <= IW'(req_off);
      stop_idx <= IW'({1'b0, req_off} + {10'd0, req.count});
      wp       <= (AW+1)'(req_off >> 2);
      act      <= 1'b1;
      first    <= 1'b1;
    end else if (cmd.scan) begin
      // The start of a run may lie in an earlier word, so it is kept.
      run   <= run_c;
      start <= start_c;
      if (found_c) begin
        stop_idx <= IW'(hit_c + XW'(1));
        wp       <= (AW+1)'(start_c >> 2);
        result_r <= base + FRAME_W'(start_c);
      end
    end else if (cmd.rmw_wr) begin
      act   <= act_c;
      first <= 1'b0;
      wp    <= wp + (AW+1)'(1);
    end
    if (issue) begin
      pend_base <= XW'({sw, 2'b00});
    end
  end

  always_comb begin
    sts.kind       = kind_r;
    sts.cnt_zero   = (cnt_r == '0);
    sts.mark_bad   = (fno_r < base) || (hi_req > hi_pool);
    sts.rel_bad    = (fno_r < base) || ({2'b00, fno_r} >= hi_pool);
    sts.sweep_last = (sw[AW-1:0] == AW'(DEPTH - 1));
    sts.found      = found_c;
    sts.scan_end   = cmd.scan && !issue && !rd_pend && !found_c;
    sts.rmw_more   = more_c;
    sts.not_head   = not_head_c;
  end

  assign rsp.status       = status_r;
  assign rsp.result_frame = result_r;
  assign rsp.free_frames  = fc;

endmodule

>>> hw/rtl/cfa_ctrl.sv
`timescale 1ns / 1ps

module cfa_ctrl import cfa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_CLEAR  = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_RMW_RD = 3'd5;
  localparam logic [2:0] S_RMW_WR = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.kind)
          KIND_CLEAR: begin
            state_next = S_CLEAR;
          end
          KIND_ALLOC: begin
            if (sts.cnt_zero) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = STS_NOSPACE;
              state_next      = S_DONE;
            end else begin
              state_next = S_SCAN;
            end
          end
          KIND_MARK: begin
            if (sts.cnt_zero) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = STS_NOSPACE;
              state_next      = S_DONE;
            end else if (sts.mark_bad) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = STS_RANGE;
              state_next      = S_DONE;
            end else begin
              state_next = S_RMW_RD;
            end
          end
          default: begin
            if (sts.rel_bad) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = STS_RANGE;
              state_next      = S_DONE;
            end else begin
              state_next = S_RMW_RD;
            end
          end
        endcase
      end
      S_CLEAR: begin
        cmd.sweep     = 1'b1;
        cmd.sweep_req = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found) begin
          state_next = S_RMW_RD;
        end else if (sts.scan_end) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = STS_NOSPACE;
          state_next      = S_DONE;
        end
      end
      S_RMW_RD: begin
        cmd.rmw_rd = 1'b1;
        state_next = S_RMW_WR;
      end
      S_RMW_WR: begin
        cmd.rmw_wr = 1'b1;
        if (sts.not_head) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = STS_NOTHEAD;
          state_next      = S_DONE;
        end else if (sts.rmw_more) begin
          state_next = S_RMW_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_DONE);

endmodule

>>> test/contiguous_frame_allocator_tb.sv
`timescale 1ns / 1ps

module contiguous_frame_allocator_tb;
  import cfa_pkg::*;

  localparam int POOL_LIMIT = MAX_FRAMES_DEF;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [FRAME_W-1:0] cfg_data = '0;
  logic               req_valid = 1'b0;
  logic               req_ready;
  req_t               req = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  rsp_t               rsp;

  contiguous_frame_allocator #(
    .MAX_FRAMES(POOL_LIMIT)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Local copy of the frame table, the free count and the registers.
  logic [1:0]  frame_tbl [POOL_LIMIT];
  int unsigned free_cnt = 0;
  int unsigned base_reg = 0;
  int unsigned pool_reg = POOL_LIMIT;
  int unsigned reserve_reg = 0;

  rsp_t        due_rsp [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  int          errors = 0;
  int          checked = 0;
  int          kind_seen [4] = '{default: 0};

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned pool_span();
    return (pool_reg > POOL_LIMIT) ? POOL_LIMIT : pool_reg;
  endfunction

  // The first frame of the run becomes a head and the rest followers.
  function automatic void claim_run(int unsigned first, int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      if (frame_tbl[first + i] == ST_FREE && free_cnt > 0) free_cnt--;
      frame_tbl[first + i] = (i == 0) ? ST_HEAD : ST_ALLOC;
    end
  endfunction

  function automatic rsp_t apply_frame_request(req_t r);
    int unsigned n, fno, cnt, run, first, i;
    bit          found;
    rsp_t        o;
    n = pool_span();
    fno = r.frame_no;
    cnt = r.count;
    o = '0;
    o.status = STS_OK;
    case (r.kind)
      KIND_CLEAR: begin
        for (i = 0; i < POOL_LIMIT; i++) frame_tbl[i] = ST_FREE;
        free_cnt = n;
        if (reserve_reg != 0 && n > 0) begin
          frame_tbl[0] = ST_HEAD;
          free_cnt = n - 1;
        end
      end
      KIND_ALLOC: begin
        run = 0;
        first = 0;
        found = 1'b0;
        if (cnt != 0) begin
          for (i = 0; i < n && !found; i++) begin
            if (frame_tbl[i] == ST_FREE) begin
              if (run == 0) first = i;
              run++;
              found = (run == cnt);
            end else begin
              run = 0;
            end
          end
        end
        if (found) begin
          claim_run(first, cnt);
          o.result_frame = FRAME_W'(base_reg + first);
        end else begin
          o.status = STS_NOSPACE;
        end
      end
      KIND_MARK: begin
        if (cnt == 0) o.status = STS_NOSPACE;
        else if (fno < base_reg || fno + cnt > base_reg + n) o.status = STS_RANGE;
        else claim_run(fno - base_reg, cnt);
      end
      default: begin
        if (fno < base_reg || fno >= base_reg + n) begin
          o.status = STS_RANGE;
        end else if (frame_tbl[fno - base_reg] != ST_HEAD) begin
          o.status = STS_NOTHEAD;
        end else begin
          // Followers go back with the head until a free frame, another head
          // or the end of the pool.
          for (i = fno - base_reg; i < n; i++) begin
            if (i != fno - base_reg && frame_tbl[i] != ST_ALLOC) break;
            if (free_cnt < COUNT_MAX) free_cnt++;
            frame_tbl[i] = ST_FREE;
          end
        end
      end
    endcase
    o.free_frames = free_cnt[COUNT_W-1:0];
    return o;
  endfunction

  // Mostly well-formed requests against the current table, with some noise.
  function automatic req_t random_request();
    int unsigned n, pick, off, idx, i, extra;
    req_t        r;
    n = pool_span();
    r.kind = KIND_CLEAR;
    r.frame_no = FRAME_W'($urandom());
    r.count = COUNT_W'($urandom_range(POOL_LIMIT));
    off = $urandom_range(n - 1);
    pick = $urandom_range(99);
    if (pick < 3) begin
      r.kind = KIND_CLEAR;
    end else if (pick < 45) begin
      r.kind = KIND_ALLOC;
      pick = $urandom_range(99);
      if (pick < 3) r.count = '0;
      else if (pick < 5) r.count = COUNT_W'(POOL_LIMIT);
      else if (pick < 15) r.count = COUNT_W'($urandom_range(n, 1));
      else r.count = COUNT_W'($urandom_range((n > 4) ? n / 4 : 1, 1));
    end else if (pick < 60) begin
      r.kind = KIND_MARK;
      pick = $urandom_range(99);
      if (pick < 70) begin
        r.frame_no = FRAME_W'(base_reg + off);
        r.count = COUNT_W'($urandom_range((n - off < 16) ? n - off : 16, 1));
      end else if (pick < 85) begin
        extra = n - off + $urandom_range(8, 1);
        r.frame_no = FRAME_W'(base_reg + off);
        r.count = COUNT_W'((extra > POOL_LIMIT) ? POOL_LIMIT : extra);
      end
    end else begin
      r.kind = KIND_RELEASE;
      pick = $urandom_range(99);
      if (pick < 80) begin
        idx = off;
        if (pick < 60) begin
          for (i = 0; i < n; i++) begin
            if (frame_tbl[(off + i) % n] == ST_HEAD) begin
              idx = (off + i) % n;
              break;
            end
          end
        end
        r.frame_no = FRAME_W'(base_reg + idx);
      end
    end
    return r;
  endfunction

  task automatic issue_request(logic [1:0] kind, logic [FRAME_W-1:0] frame_no,
                               logic [COUNT_W-1:0] count);
    req_t r;
    r.kind = kind;
    r.frame_no = frame_no;
    r.count = count;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    due_rsp.push_back(apply_frame_request(r));
    kind_seen[kind]++;
  endtask

  task automatic drain_requests();
    @(negedge clk);
    req_valid <= 1'b0;
    while (due_rsp.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= FRAME_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BASE: base_reg = value & 32'hFFFFF;
      CFG_POOL: pool_reg = value & 32'h7FF;
      default:  reserve_reg = value & 32'h1;
    endcase
  endtask

  task automatic configure_pool(int unsigned base, int unsigned frames,
                                int unsigned reserve);
    drain_requests();
    write_register(CFG_BASE, base);
    write_register(CFG_POOL, frames);
    write_register(CFG_RESERVE, reserve);
  endtask

  // Before the first clear the free count starts at zero and saturates.
  task automatic test_count_before_clear();
    issue_request(KIND_ALLOC, 20'd0, 11'd3);
    issue_request(KIND_RELEASE, 20'd0, 11'd0);
    issue_request(KIND_CLEAR, 20'd0, 11'd0);
  endtask

  task automatic test_full_pool_and_zero_counts();
    issue_request(KIND_ALLOC, 20'd0, 11'd0);
    issue_request(KIND_MARK, 20'd0, 11'd0);
    issue_request(KIND_ALLOC, 20'd0, 11'd1024);
    issue_request(KIND_ALLOC, 20'd0, 11'd1);
    issue_request(KIND_RELEASE, 20'd5, 11'd0);
    issue_request(KIND_RELEASE, 20'd0, 11'd0);
    issue_request(KIND_RELEASE, 20'd1024, 11'd0);
  endtask

  // Marks over live sequences, and releases that stop at a head, a free
  // frame and the end of the pool.
  task automatic test_run_boundaries();
    issue_request(KIND_MARK, 20'd1020, 11'd5);
    issue_request(KIND_MARK, 20'd1020, 11'd4);
    issue_request(KIND_ALLOC, 20'd0, 11'd10);
    issue_request(KIND_ALLOC, 20'd0, 11'd5);
    issue_request(KIND_MARK, 20'd12, 11'd2);
    issue_request(KIND_RELEASE, 20'd10, 11'd0);
    issue_request(KIND_RELEASE, 20'd12, 11'd0);
    issue_request(KIND_RELEASE, 20'd1020, 11'd0);
    issue_request(KIND_RELEASE, 20'd0, 11'd0);
    issue_request(KIND_CLEAR, 20'd0, 11'd0);
  endtask

  // A small pool at the top of the frame space, so allocated numbers wrap.
  task automatic test_top_of_frame_space();
    configure_pool(32'hFFFFF, 8, 1);
    issue_request(KIND_CLEAR, 20'd0, 11'd0);
    issue_request(KIND_ALLOC, 20'd0, 11'd7);
    issue_request(KIND_RELEASE, 20'hFFFFF, 11'd0);
    issue_request(KIND_ALLOC, 20'd0, 11'd8);
    issue_request(KIND_MARK, 20'hFFFFF, 11'd1);
    issue_request(KIND_RELEASE, 20'd0, 11'd0);
  endtask

  task automatic test_random_traffic(int items, int unsigned send_pct,
                                     int unsigned recv_pct, int unsigned base,
                                     int unsigned frames, int unsigned reserve,
                                     bit clear_first);
    req_t r;
    configure_pool(base, frames, reserve);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (clear_first) issue_request(KIND_CLEAR, 20'd0, 11'd0);
    repeat (items) begin
      r = random_request();
      issue_request(r.kind, r.frame_no, r.count);
    end
  endtask

  // The output is held off long enough for the block to stall its input.
  task automatic test_output_stall();
    req_t r;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 1500;
    repeat (6) begin
      r = random_request();
      issue_request(r.kind, r.frame_no, r.count);
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (due_rsp.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
      end else begin
        want = due_rsp.pop_front();
        checked++;
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          errors++;
        end
        if (rsp.result_frame !== want.result_frame) begin
          $error("result_frame: expected %h, got %h", want.result_frame,
                 rsp.result_frame);
          errors++;
        end
        if (rsp.free_frames !== want.free_frames) begin
          $error("free_frames: expected %0d, got %0d", want.free_frames,
                 rsp.free_frames);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned i;
    for (i = 0; i < POOL_LIMIT; i++) frame_tbl[i] = ST_FREE;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_count_before_clear();
    test_full_pool_and_zero_counts();
    test_run_boundaries();
    test_top_of_frame_space();
    test_random_traffic(370, 22, 80, $urandom_range(32'hFF000), 64, 1, 1'b1);
    test_random_traffic(360, 80, 22, 0, 1024, 0, 1'b1);
    test_output_stall();
    // The pool shrinks and moves without a clear; old entries stay put.
    test_random_traffic(360, 0, 0, 32'hFFC00, 8 * $urandom_range(32, 2),
                        $urandom_range(1), 1'b0);

    drain_requests();
    repeat (20) @(negedge clk);
    $display("summary: %0d clear, %0d allocate, %0d mark, %0d release requests; %0d checked",
             kind_seen[KIND_CLEAR], kind_seen[KIND_ALLOC], kind_seen[KIND_MARK],
             kind_seen[KIND_RELEASE], checked);
    $display("summary: pools of 8 to 1024 frames, bases up to the top of the frame space");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/cfa_pkg.sv
hw/rtl/cfa_dp.sv
hw/rtl/cfa_ctrl.sv
hw/rtl/contiguous_frame_allocator.sv
test/contiguous_frame_allocator_tb.sv
